### sv/h264sps_pkg.sv
// ---------------------------------------------------------------------------
// H.264 SPS parser package
// Shared request and result types and syntax constants.
// ---------------------------------------------------------------------------
package h264sps_pkg;

  // Longest exp-Golomb prefix that is still accepted, plus one.
  localparam int unsigned GOLOMB_MAX_BITS = 32;

  // Profiles that carry the chroma and scaling list branch.
  localparam logic [7:0] PROFILE_HIGH    = 8'd100;
  localparam logic [7:0] PROFILE_HIGH10  = 8'd110;
  localparam logic [7:0] PROFILE_HIGH422 = 8'd122;
  localparam logic [7:0] PROFILE_HIGH444 = 8'd144;

  // Emulation prevention byte and the extended aspect ratio code.
  localparam logic [7:0] EP_BYTE      = 8'h03;
  localparam logic [7:0] ASP_EXTENDED = 8'd255;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } sps_in_t;

  typedef struct packed {
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    logic        full_range;
    logic        full_range_present;
    logic [30:0] frame_rate;
    logic        frame_rate_present;
    logic [1:0]  parse_status;
  } sps_out_t;

endpackage

### sv/h264_sps_size_rate_parser_top.sv
// ---------------------------------------------------------------------------
// H.264 SPS size and rate parser
// Decodes picture size, full-range flag and frame rate from one SPS NAL unit.
// ---------------------------------------------------------------------------
// Each request carries one raw byte of the SPS NAL unit, header included.
// A byte is accepted in S_IDLE and then goes through the bit parser, which
// handles one bitstream bit per cycle. A dropped emulation prevention byte
// is only accepted and skips the bit parser. After the byte marked last, the
// block checks width and then height. When timing info was seen with a
// nonzero tick length, a restoring divider then computes the frame
// rate; otherwise that step is skipped. The block then presents the result
// and returns to its reset state. in_stall is high while a byte or the result
// is being worked on. One result register sits on the output side, so
// non-last bytes of the next unit are taken while a result still waits.
module h264_sps_size_rate_parser_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  h264sps_pkg::sps_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output h264sps_pkg::sps_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_BITS, S_SIZE_W, S_SIZE_H, S_DIV, S_OUT
  } state_t;

  typedef enum logic [5:0] {
    ST_HDR, ST_PROFILE, ST_CONSTR, ST_SPSID, ST_CHROMA, ST_SEPCOL,
    ST_DEPTH_L, ST_DEPTH_C, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DELTA,
    ST_LOG2FRAME, ST_POCTYPE, ST_POCLSB, ST_DZERO, ST_OFFNR, ST_OFFTB,
    ST_CYCLE, ST_CYCITEM, ST_MAXREF, ST_GAPS, ST_WIDTH, ST_HEIGHT,
    ST_FMBS, ST_MBAFF, ST_DIRECT, ST_CROPFLAG, ST_CROP_L, ST_CROP_R,
    ST_CROP_T, ST_CROP_B, ST_VUIFLAG, ST_ASPFLAG, ST_ASPIDC, ST_SAR,
    ST_OVFLAG, ST_OVAPPR, ST_SIGFLAG, ST_VFORMAT, ST_FULLRANGE,
    ST_CDFLAG, ST_CDESC, ST_CLFLAG, ST_CLTOP, ST_CLBOT, ST_TIMFLAG,
    ST_UNITS, ST_TSCALE, ST_DONE, ST_ERROR
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic [1:0]  zrun_r, zrun_nxt, pos_r, pos_nxt, guard_r, guard_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [3:0]  bcnt_r, bcnt_nxt;
  logic        last_r, last_nxt;
  logic        exp_r, exp_nxt, suf_r, suf_nxt;
  logic [5:0]  cnt_r, cnt_nxt, pre_r, pre_nxt;
  logic [31:0] acc_r, acc_nxt, rep_r, rep_nxt;
  logic [2:0]  list_r, list_nxt;
  logic [6:0]  coef_r, coef_nxt;
  logic [7:0]  lscale_r, lscale_nxt, nscale_r, nscale_nxt;
  logic        hp_r, hp_nxt;
  logic [31:0] wmb_r, wmb_nxt, hmb_r, hmb_nxt;
  logic [32:0] croph_r, croph_nxt, cropv_r, cropv_nxt;
  logic [1:0]  rng_r, rng_nxt;
  logic [31:0] units_r, units_nxt, tscale_r, tscale_nxt;
  logic        tseen_r, tseen_nxt;

  // Result staging and divider.
  logic [15:0] resw_r, resw_nxt, resh_r, resh_nxt;
  logic [1:0]  resst_r, resst_nxt;
  logic        rok_r, rok_nxt;
  logic [32:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [31:0] dvd_r, dvd_nxt, quo_r, quo_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  h264sps_pkg::sps_out_t out_data_r, out_data_nxt;

  // Bit parser scratch.
  logic        b, fin, go, g_exp;
  step_t       g_step;
  logic [5:0]  g_n, cdec, pinc;
  logic [31:0] v, ashift, onehot;
  logic [7:0]  mag8, d8, ns8;
  logic [6:0]  cdec7;
  logic        drop;
  logic [37:0] diff;
  logic [33:0] trial;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;  step_nxt = step_r;
    zrun_nxt = zrun_r;  pos_nxt = pos_r;  guard_nxt = guard_r;
    sh_nxt = sh_r;  bcnt_nxt = bcnt_r;  last_nxt = last_r;
    exp_nxt = exp_r;  suf_nxt = suf_r;  cnt_nxt = cnt_r;  pre_nxt = pre_r;
    acc_nxt = acc_r;  rep_nxt = rep_r;  list_nxt = list_r;  coef_nxt = coef_r;
    lscale_nxt = lscale_r;  nscale_nxt = nscale_r;  hp_nxt = hp_r;
    wmb_nxt = wmb_r;  hmb_nxt = hmb_r;  croph_nxt = croph_r;  cropv_nxt = cropv_r;
    rng_nxt = rng_r;  units_nxt = units_r;  tscale_nxt = tscale_r;
    tseen_nxt = tseen_r;
    resw_nxt = resw_r;  resh_nxt = resh_r;  resst_nxt = resst_r;  rok_nxt = rok_r;
    rem_nxt = rem_r;  dvs_nxt = dvs_r;  dvd_nxt = dvd_r;  quo_nxt = quo_r;
    dcnt_nxt = dcnt_r;
    out_valid_nxt = out_valid_r;  out_data_nxt = out_data_r;

    b = sh_r[7];  fin = 1'b0;  go = 1'b0;  g_exp = 1'b0;  g_step = ST_HDR;
    g_n = 6'd0;  v = '0;
    ashift = {acc_r[30:0], b};
    cdec = cnt_r - 6'd1;
    pinc = pre_r + 6'd1;
    onehot = 32'd1 << pre_r[4:0];
    mag8 = v[8:1];  d8 = '0;  ns8 = '0;  cdec7 = coef_r - 7'd1;
    drop = (pos_r == 2'd3) && (zrun_r >= 2'd2) &&
           (in_data.data_byte == h264sps_pkg::EP_BYTE) && (guard_r == 2'd0);
    diff = '0;
    trial = {rem_r, dvd_r[31]};

    // The result register empties when the consumer takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          zrun_nxt = (in_data.data_byte == 8'd0) ?
                     ((zrun_r == 2'd3) ? 2'd3 : zrun_r + 2'd1) : 2'd0;
          if (pos_r != 2'd3) pos_nxt = pos_r + 2'd1;
          last_nxt = in_data.last_byte;
          if (drop) begin
            guard_nxt = 2'd2;
            if (in_data.last_byte) state_nxt = S_SIZE_W;
          end else begin
            if (guard_r != 2'd0) guard_nxt = guard_r - 2'd1;
            sh_nxt = in_data.data_byte;
            bcnt_nxt = 4'd8;
            state_nxt = S_BITS;
          end
        end
      end

      S_BITS: begin
        sh_nxt = {sh_r[6:0], 1'b0};
        bcnt_nxt = bcnt_r - 4'd1;
        if (bcnt_r == 4'd1) state_nxt = last_r ? S_SIZE_W : S_IDLE;
        // One bitstream bit per cycle: fixed field, Golomb prefix or suffix.
        if (step_r < ST_DONE) begin
          if (!exp_r) begin
            acc_nxt = ashift;
            cdec = (cnt_r != 6'd0) ? cnt_r - 6'd1 : 6'd0;
            cnt_nxt = cdec;
            if (cdec == 6'd0) begin
              fin = 1'b1;  v = ashift;
            end
          end else if (!suf_r) begin
            if (!b) begin
              pre_nxt = pinc;
              if (32'(pinc) >= h264sps_pkg::GOLOMB_MAX_BITS) step_nxt = ST_ERROR;
            end else if (pre_r == 6'd0) begin
              fin = 1'b1;  v = '0;
            end else begin
              suf_nxt = 1'b1;  cnt_nxt = pre_r;  acc_nxt = '0;
            end
          end else begin
            acc_nxt = ashift;
            cnt_nxt = cdec;
            if (cdec == 6'd0) begin
              fin = 1'b1;  v = (onehot | ashift) - 32'd1;
            end
          end
        end
        // Element complete: store it and choose the next syntax element.
        if (fin) begin
          mag8 = v[8:1] + {7'd0, v[0]};
          d8 = v[0] ? mag8 : (8'd0 - mag8);
          ns8 = lscale_r + d8;
          go = 1'b1;
          case (step_r)
            ST_HDR: begin g_step = ST_PROFILE; g_n = 6'd8; end
            ST_PROFILE: begin
              hp_nxt = (v == 32'(h264sps_pkg::PROFILE_HIGH)) ||
                       (v == 32'(h264sps_pkg::PROFILE_HIGH10)) ||
                       (v == 32'(h264sps_pkg::PROFILE_HIGH422)) ||
                       (v == 32'(h264sps_pkg::PROFILE_HIGH444));
              g_step = ST_CONSTR; g_n = 6'd16;
            end
            ST_CONSTR: begin g_step = ST_SPSID; g_exp = 1'b1; end
            ST_SPSID: begin g_step = hp_r ? ST_CHROMA : ST_LOG2FRAME; g_exp = 1'b1; end
            ST_CHROMA: begin
              if (v == 32'd3) begin g_step = ST_SEPCOL; g_n = 6'd1; end
              else begin g_step = ST_DEPTH_L; g_exp = 1'b1; end
            end
            ST_SEPCOL: begin g_step = ST_DEPTH_L; g_exp = 1'b1; end
            ST_DEPTH_L: begin g_step = ST_DEPTH_C; g_exp = 1'b1; end
            ST_DEPTH_C: begin g_step = ST_BYPASS; g_n = 6'd1; end
            ST_BYPASS: begin g_step = ST_MATRIX; g_n = 6'd1; end
            ST_MATRIX: begin
              if (v != 32'd0) begin
                list_nxt = 3'd0; g_step = ST_LISTFLAG; g_n = 6'd1;
              end else begin
                g_step = ST_LOG2FRAME; g_exp = 1'b1;
              end
            end
            ST_LISTFLAG: begin
              if (v != 32'd0) begin
                coef_nxt = (list_r < 3'd6) ? 7'd16 : 7'd64;
                lscale_nxt = 8'd8;  nscale_nxt = 8'd8;
                g_step = ST_DELTA; g_exp = 1'b1;
              end else if (list_r == 3'd7) begin
                g_step = ST_LOG2FRAME; g_exp = 1'b1;
              end else begin
                list_nxt = list_r + 3'd1; g_step = ST_LISTFLAG; g_n = 6'd1;
              end
            end
            ST_DELTA: begin
              nscale_nxt = ns8;
              if (ns8 != 8'd0) lscale_nxt = ns8;
              coef_nxt = cdec7;
              if (cdec7 != 7'd0 && ns8 != 8'd0) begin
                g_step = ST_DELTA; g_exp = 1'b1;
              end else if (list_r == 3'd7) begin
                g_step = ST_LOG2FRAME; g_exp = 1'b1;
              end else begin
                list_nxt = list_r + 3'd1; g_step = ST_LISTFLAG; g_n = 6'd1;
              end
            end
            ST_LOG2FRAME: begin g_step = ST_POCTYPE; g_exp = 1'b1; end
            ST_POCTYPE: begin
              if (v == 32'd0) begin g_step = ST_POCLSB; g_exp = 1'b1; end
              else if (v == 32'd1) begin g_step = ST_DZERO; g_n = 6'd1; end
              else begin g_step = ST_MAXREF; g_exp = 1'b1; end
            end
            ST_POCLSB: begin g_step = ST_MAXREF; g_exp = 1'b1; end
            ST_DZERO: begin g_step = ST_OFFNR; g_exp = 1'b1; end
            ST_OFFNR: begin g_step = ST_OFFTB; g_exp = 1'b1; end
            ST_OFFTB: begin g_step = ST_CYCLE; g_exp = 1'b1; end
            ST_CYCLE: begin
              rep_nxt = v;
              g_step = (v == 32'd0) ? ST_MAXREF : ST_CYCITEM; g_exp = 1'b1;
            end
            ST_CYCITEM: begin
              rep_nxt = rep_r - 32'd1;
              g_step = (rep_r == 32'd1) ? ST_MAXREF : ST_CYCITEM; g_exp = 1'b1;
            end
            ST_MAXREF: begin g_step = ST_GAPS; g_n = 6'd1; end
            ST_GAPS: begin g_step = ST_WIDTH; g_exp = 1'b1; end
            ST_WIDTH: begin wmb_nxt = v; g_step = ST_HEIGHT; g_exp = 1'b1; end
            ST_HEIGHT: begin hmb_nxt = v; g_step = ST_FMBS; g_n = 6'd1; end
            ST_FMBS: begin g_step = (v != 32'd0) ? ST_DIRECT : ST_MBAFF; g_n = 6'd1; end
            ST_MBAFF: begin g_step = ST_DIRECT; g_n = 6'd1; end
            ST_DIRECT: begin g_step = ST_CROPFLAG; g_n = 6'd1; end
            ST_CROPFLAG: begin
              if (v != 32'd0) begin g_step = ST_CROP_L; g_exp = 1'b1; end
              else begin g_step = ST_VUIFLAG; g_n = 6'd1; end
            end
            ST_CROP_L: begin croph_nxt = {1'b0, v}; g_step = ST_CROP_R; g_exp = 1'b1; end
            ST_CROP_R: begin
              croph_nxt = croph_r + {1'b0, v}; g_step = ST_CROP_T; g_exp = 1'b1;
            end
            ST_CROP_T: begin cropv_nxt = {1'b0, v}; g_step = ST_CROP_B; g_exp = 1'b1; end
            ST_CROP_B: begin
              cropv_nxt = cropv_r + {1'b0, v}; g_step = ST_VUIFLAG; g_n = 6'd1;
            end
            ST_VUIFLAG: begin
              if (v != 32'd0) begin g_step = ST_ASPFLAG; g_n = 6'd1; end
              else begin go = 1'b0; step_nxt = ST_DONE; end
            end
            ST_ASPFLAG: begin
              if (v != 32'd0) begin g_step = ST_ASPIDC; g_n = 6'd8; end
              else begin g_step = ST_OVFLAG; g_n = 6'd1; end
            end
            ST_ASPIDC: begin
              if (v == 32'(h264sps_pkg::ASP_EXTENDED)) begin g_step = ST_SAR; g_n = 6'd32; end
              else begin g_step = ST_OVFLAG; g_n = 6'd1; end
            end
            ST_SAR: begin g_step = ST_OVFLAG; g_n = 6'd1; end
            ST_OVFLAG: begin g_step = (v != 32'd0) ? ST_OVAPPR : ST_SIGFLAG; g_n = 6'd1; end
            ST_OVAPPR: begin g_step = ST_SIGFLAG; g_n = 6'd1; end
            ST_SIGFLAG: begin
              if (v != 32'd0) begin g_step = ST_VFORMAT; g_n = 6'd3; end
              else begin g_step = ST_CLFLAG; g_n = 6'd1; end
            end
            ST_VFORMAT: begin g_step = ST_FULLRANGE; g_n = 6'd1; end
            ST_FULLRANGE: begin
              rng_nxt = {1'b1, v[0]}; g_step = ST_CDFLAG; g_n = 6'd1;
            end
            ST_CDFLAG: begin
              if (v != 32'd0) begin g_step = ST_CDESC; g_n = 6'd24; end
              else begin g_step = ST_CLFLAG; g_n = 6'd1; end
            end
            ST_CDESC: begin g_step = ST_CLFLAG; g_n = 6'd1; end
            ST_CLFLAG: begin
              if (v != 32'd0) begin g_step = ST_CLTOP; g_exp = 1'b1; end
              else begin g_step = ST_TIMFLAG; g_n = 6'd1; end
            end
            ST_CLTOP: begin g_step = ST_CLBOT; g_exp = 1'b1; end
            ST_CLBOT: begin g_step = ST_TIMFLAG; g_n = 6'd1; end
            ST_TIMFLAG: begin
              if (v != 32'd0) begin g_step = ST_UNITS; g_n = 6'd32; end
              else begin go = 1'b0; step_nxt = ST_DONE; end
            end
            ST_UNITS: begin units_nxt = v; g_step = ST_TSCALE; g_n = 6'd32; end
            ST_TSCALE: begin
              tscale_nxt = v; tseen_nxt = 1'b1; go = 1'b0; step_nxt = ST_DONE;
            end
            default: begin go = 1'b0; step_nxt = ST_ERROR; end
          endcase
          if (go) begin
            step_nxt = g_step;
            exp_nxt = g_exp;
            cnt_nxt = g_exp ? 6'd0 : g_n;
            acc_nxt = '0;
            if (g_exp) begin
              suf_nxt = 1'b0;  pre_nxt = 6'd0;
            end
          end
        end
      end

      // Status and width check: one subtract against the cropped size.
      S_SIZE_W: begin
        diff = {2'b0, wmb_r, 4'd0} + 38'd16 - {4'd0, croph_r, 1'b0};
        resw_nxt = diff[15:0];
        if (step_r == ST_ERROR) resst_nxt = h264sps_pkg::STATUS_RANGE;
        else if (step_r != ST_DONE) resst_nxt = h264sps_pkg::STATUS_SHORT;
        else if (diff[37:16] != '0) resst_nxt = h264sps_pkg::STATUS_RANGE;
        else resst_nxt = h264sps_pkg::STATUS_OK;
        state_nxt = S_SIZE_H;
      end

      // Height check, then load the divider for the tick rate over twice the
      // tick length.
      S_SIZE_H: begin
        diff = {2'b0, hmb_r, 4'd0} + 38'd16 - {4'd0, cropv_r, 1'b0};
        resh_nxt = diff[15:0];
        if (resst_r == h264sps_pkg::STATUS_OK && diff[37:16] != '0) begin
          resst_nxt = h264sps_pkg::STATUS_RANGE;
        end
        rok_nxt = tseen_r && (units_r != 32'd0);
        rem_nxt = '0;
        dvd_nxt = tscale_r;
        dvs_nxt = {units_r, 1'b0};
        quo_nxt = '0;
        dcnt_nxt = 6'd32;
        state_nxt = (tseen_r && (units_r != 32'd0)) ? S_DIV : S_OUT;
      end

      // Restoring divider, one quotient bit per cycle.
      S_DIV: begin
        dvd_nxt = {dvd_r[30:0], 1'b0};
        if (trial >= {1'b0, dvs_r}) begin
          rem_nxt = 33'(trial - {1'b0, dvs_r});
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = trial[32:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 6'd1;
        if (dcnt_r == 6'd1) state_nxt = S_OUT;
      end

      // Hand the result over and return the parser to its reset state.
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = '0;
          out_data_nxt.parse_status = resst_r;
          if (resst_r == h264sps_pkg::STATUS_OK) begin
            out_data_nxt.pic_width = resw_r;
            out_data_nxt.pic_height = resh_r;
            out_data_nxt.full_range = rng_r[0];
            out_data_nxt.full_range_present = rng_r[1];
            out_data_nxt.frame_rate = rok_r ? quo_r[30:0] : 31'd0;
            out_data_nxt.frame_rate_present = rok_r;
          end
          zrun_nxt = '0;  pos_nxt = '0;  guard_nxt = '0;
          step_nxt = ST_HDR;  exp_nxt = 1'b0;  suf_nxt = 1'b0;
          cnt_nxt = 6'd8;  pre_nxt = '0;  acc_nxt = '0;  rep_nxt = '0;
          list_nxt = '0;  coef_nxt = '0;  lscale_nxt = 8'd8;  nscale_nxt = 8'd8;
          hp_nxt = 1'b0;  wmb_nxt = '0;  hmb_nxt = '0;
          croph_nxt = '0;  cropv_nxt = '0;  rng_nxt = '0;
          units_nxt = '0;  tscale_nxt = '0;  tseen_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer, parser state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;  out_valid_r <= 1'b0;
      zrun_r <= '0;  pos_r <= '0;  guard_r <= '0;  bcnt_r <= '0;
      step_r <= ST_HDR;  exp_r <= 1'b0;  suf_r <= 1'b0;
      cnt_r <= 6'd8;  pre_r <= '0;  acc_r <= '0;  rep_r <= '0;
      list_r <= '0;  coef_r <= '0;  lscale_r <= 8'd8;  nscale_r <= 8'd8;
      hp_r <= 1'b0;  wmb_r <= '0;  hmb_r <= '0;
      croph_r <= '0;  cropv_r <= '0;  rng_r <= '0;
      units_r <= '0;  tscale_r <= '0;  tseen_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  out_valid_r <= out_valid_nxt;
      zrun_r <= zrun_nxt;  pos_r <= pos_nxt;  guard_r <= guard_nxt;
      bcnt_r <= bcnt_nxt;
      step_r <= step_nxt;  exp_r <= exp_nxt;  suf_r <= suf_nxt;
      cnt_r <= cnt_nxt;  pre_r <= pre_nxt;  acc_r <= acc_nxt;  rep_r <= rep_nxt;
      list_r <= list_nxt;  coef_r <= coef_nxt;
      lscale_r <= lscale_nxt;  nscale_r <= nscale_nxt;
      hp_r <= hp_nxt;  wmb_r <= wmb_nxt;  hmb_r <= hmb_nxt;
      croph_r <= croph_nxt;  cropv_r <= cropv_nxt;  rng_r <= rng_nxt;
      units_r <= units_nxt;  tscale_r <= tscale_nxt;  tseen_r <= tseen_nxt;
    end
    sh_r <= sh_nxt;  last_r <= last_nxt;
    resw_r <= resw_nxt;  resh_r <= resh_nxt;  resst_r <= resst_nxt;  rok_r <= rok_nxt;
    rem_r <= rem_nxt;  dvs_r <= dvs_nxt;  dvd_r <= dvd_nxt;  quo_r <= quo_nxt;
    dcnt_r <= dcnt_nxt;  out_data_r <= out_data_nxt;
  end

  // The bit parser never runs out of bits while it is active.
  a_bits_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BITS |-> bcnt_r != 4'd0)
    else $error("bit parser active with no bits left");

  // A failed parse carries no size or rate.
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.parse_status != h264sps_pkg::STATUS_OK |->
    out_data_r.pic_width == 16'd0 && out_data_r.frame_rate_present == 1'b0)
    else $error("error result carries payload");

  // A dropped byte arms the guard for the next two bytes.
  a_guard_arm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && in_valid && drop |=> guard_r == 2'd2)
    else $error("emulation guard not armed");

endmodule
